@@ sv/prd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinhole ray direction package
// Shared types, register codes and datapath widths of the primary ray block.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int COORD_BITS = 12;
    localparam int JIT_FRAC   = 16;
    localparam int OUT_FRAC   = 30;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 13;
    localparam int EXT_W      = 31;
    localparam int EYE_W      = 32;

    localparam int MAG_W   = COORD_BITS + JIT_FRAC;
    localparam int PROD_W  = MAG_W + EXT_W;
    localparam int QUO_W   = PROD_W + 1 - JIT_FRAC;
    localparam int WORLD_W = QUO_W + 1;
    localparam int WORLD_LAT = QUO_W + 4;

    localparam int VEC_W  = WORLD_W + 1;
    localparam int ABS_W  = VEC_W - 1;
    localparam int NRM_W  = 31;
    localparam int SQ_W   = 2 * NRM_W;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int NUM_W  = NRM_W + OUT_FRAC + 1;
    localparam int DQ_W   = NUM_W - NRM_W;
    localparam int DIR_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_COLUMNS = 3'd0,
        REG_PIXEL_ROWS    = 3'd1,
        REG_WINDOW_WIDTH  = 3'd2,
        REG_WINDOW_HEIGHT = 3'd3,
        REG_EYE_X         = 3'd4,
        REG_EYE_Y         = 3'd5,
        REG_EYE_Z         = 3'd6,
        REG_JITTER_ENABLE = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic        [11:0] pixel_x;
        logic        [11:0] pixel_y;
        logic signed [15:0] jitter_x;
        logic signed [15:0] jitter_y;
    } ray_in_t;

    typedef struct packed {
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic               zero_length;
    } ray_out_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } ray_ctl_t;

endpackage

@@ sv/pinhole_ray_direction_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinhole camera primary ray direction
// Maps a pixel to the view window and returns the unit ray direction.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and returns one direction word per
// clock while the output buffer is not full; each result passes through the
// 44-step coordinate divider, the 32-step square root and the 31-step
// normalizing divider, each step a pipeline stage. A two-word output buffer
// lets in_ready follow a registered flag, so the pipeline only holds after the
// output side has refused a word. Registers are to be written by the user only
// while no word is in flight; the block itself does not enforce this.
module pinhole_ray_direction_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  prd_pkg::ray_in_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output prd_pkg::ray_out_t                  out_data,
    input  logic                               cfg_write,
    input  logic [prd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W   = prd_pkg::CNT_W;
    localparam int EXT_W   = prd_pkg::EXT_W;
    localparam int EYE_W   = prd_pkg::EYE_W;
    localparam int WORLD_W = prd_pkg::WORLD_W;
    localparam int VEC_W   = prd_pkg::VEC_W;
    localparam int ABS_W   = prd_pkg::ABS_W;
    localparam int NRM_W   = prd_pkg::NRM_W;
    localparam int SQ_W    = prd_pkg::SQ_W;
    localparam int SUM_W   = prd_pkg::SUM_W;
    localparam int ROOT_W  = prd_pkg::ROOT_W;
    localparam int REM_W   = prd_pkg::REM_W;
    localparam int NUM_W   = prd_pkg::NUM_W;
    localparam int DQ_W    = prd_pkg::DQ_W;
    localparam int DIR_W   = prd_pkg::DIR_W;
    localparam int OUT_FRAC = prd_pkg::OUT_FRAC;
    localparam int CTL_N   = 70;
    localparam int TOTAL   = prd_pkg::WORLD_LAT + 72;

    logic [CNT_W-1:0]         cols_reg;
    logic [CNT_W-1:0]         rows_reg;
    logic [EXT_W-1:0]         wwid_reg;
    logic [EXT_W-1:0]         whgt_reg;
    logic signed [EYE_W-1:0]  eye_x_reg;
    logic signed [EYE_W-1:0]  eye_y_reg;
    logic signed [EYE_W-1:0]  eye_z_reg;
    logic                     jit_en_reg;
    logic [CNT_W-1:0]         cols_eff;
    logic [CNT_W-1:0]         rows_eff;

    logic                     adv;
    logic [TOTAL-1:0]         vld_reg;
    logic signed [WORLD_W-1:0] wx;
    logic signed [WORLD_W-1:0] wy;

    logic signed [VEC_W-1:0]  v_reg    [3];
    logic [2:0]               negb_reg;
    logic [ABS_W-1:0]         magb_reg [3];
    logic [ABS_W-1:0]         mx01;
    logic [ABS_W-1:0]         mx;
    prd_pkg::ray_ctl_t        ctl_reg  [CTL_N];

    logic [ABS_W-1:0]         nrm_reg  [4][3];
    logic [ABS_W-1:0]         nmx_reg  [4];
    logic [ABS_W-1:0]         nrm_next [4][3];
    logic [ABS_W-1:0]         nmx_next [4];
    logic [ABS_W-1:0]         tmx;
    int                       hi;
    int                       lo;

    logic [NRM_W-1:0]         mq_reg   [3];
    logic [SQ_W-1:0]          sq_reg   [3];

    logic [SUM_W-1:0]         srest_reg  [33];
    logic [ROOT_W-1:0]        root_reg   [33];
    logic [REM_W-1:0]         srem_reg   [33];
    logic [NRM_W-1:0]         sm_reg     [33][3];
    logic [SUM_W-1:0]         srest_next [33];
    logic [ROOT_W-1:0]        root_next  [33];
    logic [REM_W-1:0]         srem_next  [33];
    logic [REM_W+1:0]         st;
    logic [REM_W+1:0]         strial;
    logic                     sge;

    logic [NUM_W-1:0]         num      [3];
    logic [ROOT_W-1:0]        dl_reg   [32];
    logic [ROOT_W-1:0]        drem_reg [32][3];
    logic [DQ_W-1:0]          dnq_reg  [32][3];
    logic [ROOT_W-1:0]        drem_next [32][3];
    logic [DQ_W-1:0]          dnq_next  [32][3];
    logic [ROOT_W:0]          dt;
    logic                     dge;

    prd_pkg::ray_ctl_t        fctl;
    prd_pkg::ray_out_t        res;
    prd_pkg::ray_out_t        out_data_reg;
    prd_pkg::ray_out_t        skid_reg;
    logic                     out_valid_reg;
    logic                     skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= CNT_W'(640);
            rows_reg   <= CNT_W'(480);
            wwid_reg   <= EXT_W'(524288);
            whgt_reg   <= EXT_W'(393216);
            eye_x_reg  <= EYE_W'(262144);
            eye_y_reg  <= EYE_W'(196608);
            eye_z_reg  <= EYE_W'(327680);
            jit_en_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (prd_pkg::cfg_reg_t'(cfg_index))
                prd_pkg::REG_PIXEL_COLUMNS: cols_reg   <= cfg_data[CNT_W-1:0];
                prd_pkg::REG_PIXEL_ROWS:    rows_reg   <= cfg_data[CNT_W-1:0];
                prd_pkg::REG_WINDOW_WIDTH:  wwid_reg   <= cfg_data[EXT_W-1:0];
                prd_pkg::REG_WINDOW_HEIGHT: whgt_reg   <= cfg_data[EXT_W-1:0];
                prd_pkg::REG_EYE_X:         eye_x_reg  <= cfg_data;
                prd_pkg::REG_EYE_Y:         eye_y_reg  <= cfg_data;
                prd_pkg::REG_EYE_Z:         eye_z_reg  <= cfg_data;
                prd_pkg::REG_JITTER_ENABLE: jit_en_reg <= cfg_data[0];
            endcase
        end
    end

    assign cols_eff = (cols_reg == '0) ? CNT_W'(1) : cols_reg;
    assign rows_eff = (rows_reg == '0) ? CNT_W'(1) : rows_reg;

    assign in_ready = !skid_v_reg;
    assign adv      = !skid_v_reg;

    prd_world u_world_x (
        .clk           (clk),
        .en            (adv),
        .pixel         (in_data.pixel_x),
        .jitter        (in_data.jitter_x),
        .jitter_enable (jit_en_reg),
        .count         (cols_eff),
        .extent        (wwid_reg),
        .world         (wx)
    );

    prd_world u_world_y (
        .clk           (clk),
        .en            (adv),
        .pixel         (in_data.pixel_y),
        .jitter        (in_data.jitter_y),
        .jitter_enable (jit_en_reg),
        .count         (rows_eff),
        .extent        (whgt_reg),
        .world         (wy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    always_comb
    begin
        mx01 = (magb_reg[0] >= magb_reg[1]) ? magb_reg[0] : magb_reg[1];
        mx   = (mx01 >= magb_reg[2]) ? mx01 : magb_reg[2];

        nmx_next[0] = mx;
        for (int i = 0; i < 3; i++)
        begin
            nrm_next[0][i] = magb_reg[i];
        end
        tmx = '0;
        hi  = 0;
        lo  = 0;
        for (int s = 1; s <= 3; s++)
        begin
            hi  = 128 >> (2 * s);
            lo  = hi / 2;
            tmx = nmx_reg[s-1];
            for (int i = 0; i < 3; i++)
            begin
                nrm_next[s][i] = nrm_reg[s-1][i];
            end
            if ((tmx >> (ABS_W - hi)) == '0)
            begin
                tmx = tmx << hi;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_next[s][i] = nrm_next[s][i] << hi;
                end
            end
            if ((tmx >> (ABS_W - lo)) == '0)
            begin
                tmx = tmx << lo;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_next[s][i] = nrm_next[s][i] << lo;
                end
            end
            nmx_next[s] = tmx;
        end

        srest_next[0] = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        root_next[0]  = '0;
        srem_next[0]  = '0;
        st     = '0;
        strial = '0;
        sge    = 1'b0;
        for (int j = 1; j <= 32; j++)
        begin
            st     = {srem_reg[j-1], srest_reg[j-1][SUM_W-1 -: 2]};
            strial = {1'b0, root_reg[j-1], 2'b01};
            sge    = (st >= strial);
            srem_next[j]  = sge ? REM_W'(st - strial) : st[REM_W-1:0];
            root_next[j]  = {root_reg[j-1][ROOT_W-2:0], sge};
            srest_next[j] = srest_reg[j-1] << 2;
        end

        for (int i = 0; i < 3; i++)
        begin
            num[i] = (NUM_W'(sm_reg[32][i]) << OUT_FRAC) + NUM_W'(root_reg[32] >> 1);
            drem_next[0][i] = ROOT_W'(num[i][NUM_W-1 -: NRM_W]);
            dnq_next[0][i]  = num[i][DQ_W-1:0];
        end
        dt  = '0;
        dge = 1'b0;
        for (int k = 1; k < 32; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dt  = {drem_reg[k-1][i], dnq_reg[k-1][i][DQ_W-1]};
                dge = (dt >= {1'b0, dl_reg[k-1]});
                drem_next[k][i] = dge ? ROOT_W'(dt - {1'b0, dl_reg[k-1]})
                                      : dt[ROOT_W-1:0];
                dnq_next[k][i]  = {dnq_reg[k-1][i][DQ_W-2:0], dge};
            end
        end

        fctl = ctl_reg[CTL_N-1];
        res.zero_length = fctl.zero;
        res.dir_x = fctl.zero ? '0 : fctl.neg[0] ? DIR_W'(0) - DIR_W'(dnq_reg[31][0])
                                                  : DIR_W'(dnq_reg[31][0]);
        res.dir_y = fctl.zero ? '0 : fctl.neg[1] ? DIR_W'(0) - DIR_W'(dnq_reg[31][1])
                                                  : DIR_W'(dnq_reg[31][1]);
        res.dir_z = fctl.zero ? '0 : fctl.neg[2] ? DIR_W'(0) - DIR_W'(dnq_reg[31][2])
                                                  : DIR_W'(dnq_reg[31][2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_reg[0] <= VEC_W'(wx) - VEC_W'(eye_x_reg);
            v_reg[1] <= VEC_W'(wy) - VEC_W'(eye_y_reg);
            v_reg[2] <= VEC_W'(0) - VEC_W'(eye_z_reg);
            for (int i = 0; i < 3; i++)
            begin
                negb_reg[i] <= v_reg[i][VEC_W-1];
                magb_reg[i] <= v_reg[i][VEC_W-1] ? ABS_W'(-v_reg[i]) : ABS_W'(v_reg[i]);
            end
            ctl_reg[0] <= '{neg: negb_reg, zero: (mx == '0)};
            for (int k = 1; k < CTL_N; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
            for (int s = 0; s <= 3; s++)
            begin
                nmx_reg[s] <= nmx_next[s];
                for (int i = 0; i < 3; i++)
                begin
                    nrm_reg[s][i] <= nrm_next[s][i];
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                mq_reg[i] <= nrm_reg[3][i][ABS_W-1 -: NRM_W];
                sq_reg[i] <= SQ_W'(nrm_reg[3][i][ABS_W-1 -: NRM_W])
                           * SQ_W'(nrm_reg[3][i][ABS_W-1 -: NRM_W]);
                sm_reg[0][i] <= mq_reg[i];
            end
            for (int j = 0; j <= 32; j++)
            begin
                srest_reg[j] <= srest_next[j];
                root_reg[j]  <= root_next[j];
                srem_reg[j]  <= srem_next[j];
            end
            for (int j = 1; j <= 32; j++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sm_reg[j][i] <= sm_reg[j-1][i];
                end
            end
            dl_reg[0] <= root_reg[32];
            for (int k = 1; k < 32; k++)
            begin
                dl_reg[k] <= dl_reg[k-1];
            end
            for (int k = 0; k < 32; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[k][i] <= drem_next[k][i];
                    dnq_reg[k][i]  <= dnq_next[k][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_v_reg    <= 1'b0;
        end
        else
        begin
            priority if (skid_v_reg)
            begin
                if (out_ready)
                begin
                    skid_v_reg <= 1'b0;
                end
            end
            else if (vld_reg[TOTAL-1])
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_v_reg <= 1'b1;
                end
            end
            else
            begin
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_ready)
            begin
                out_data_reg <= skid_reg;
            end
        end
        else if (vld_reg[TOTAL-1])
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_data_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ sv/prd_world.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window coordinate mapping
// Turns one pixel coordinate plus optional jitter into a signed window point,
// coordinate * extent / count, rounded, through a bit-per-stage divider.
// ----------------------------------------------------------------------------
module prd_world (
    input  logic                                     clk,
    input  logic                                     en,
    input  logic [prd_pkg::COORD_BITS-1:0]           pixel,
    input  logic signed [15:0]                       jitter,
    input  logic                                     jitter_enable,
    input  logic [prd_pkg::CNT_W-1:0]                count,
    input  logic [prd_pkg::EXT_W-1:0]                extent,
    output logic signed [prd_pkg::WORLD_W-1:0]       world
);

    localparam int CW      = prd_pkg::MAG_W + 1;
    localparam int MAG_W   = prd_pkg::MAG_W;
    localparam int PROD_W  = prd_pkg::PROD_W;
    localparam int QUO_W   = prd_pkg::QUO_W;
    localparam int CNT_W   = prd_pkg::CNT_W;
    localparam int WORLD_W = prd_pkg::WORLD_W;
    localparam int JF      = prd_pkg::JIT_FRAC;
    localparam int NEG_N   = QUO_W + 3;

    logic signed [CW-1:0]       coord;
    logic [MAG_W-1:0]           mag_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [PROD_W:0]            rnd;
    logic [CNT_W-1:0]           drem_reg  [QUO_W+1];
    logic [QUO_W-1:0]           dnq_reg   [QUO_W+1];
    logic [CNT_W-1:0]           drem_next [QUO_W+1];
    logic [QUO_W-1:0]           dnq_next  [QUO_W+1];
    logic [CNT_W:0]             t;
    logic                       ge;
    logic [NEG_N-1:0]           neg_reg;
    logic signed [WORLD_W-1:0]  world_reg;

    always_comb
    begin
        coord = signed'({1'b0, pixel, {JF{1'b0}}})
              + (jitter_enable ? CW'(jitter) : CW'(0));
        rnd = {1'b0, prod_reg} + (PROD_W + 1)'({count, {(JF - 1){1'b0}}});
        drem_next[0] = '0;
        dnq_next[0]  = rnd[PROD_W:JF];
        t  = '0;
        ge = 1'b0;
        for (int k = 1; k <= QUO_W; k++)
        begin
            t  = {drem_reg[k-1], dnq_reg[k-1][QUO_W-1]};
            ge = (t >= {1'b0, count});
            drem_next[k] = ge ? CNT_W'(t - {1'b0, count}) : t[CNT_W-1:0];
            dnq_next[k]  = {dnq_reg[k-1][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= coord[CW-1] ? MAG_W'(-coord) : MAG_W'(coord);
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(extent);
            neg_reg  <= {neg_reg[NEG_N-2:0], coord[CW-1]};
            for (int k = 0; k <= QUO_W; k++)
            begin
                drem_reg[k] <= drem_next[k];
                dnq_reg[k]  <= dnq_next[k];
            end
            world_reg <= neg_reg[NEG_N-1] ? WORLD_W'(0) - WORLD_W'(dnq_reg[QUO_W])
                                          : WORLD_W'(dnq_reg[QUO_W]);
        end
    end

    assign world = world_reg;

endmodule

@@ sv/prd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinhole ray direction port checker
// Watches the top level's ports and flags results or flow control gone wrong.
// ----------------------------------------------------------------------------
module prd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input prd_pkg::ray_out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output word changed while stalled.");

    a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.zero_length |->
            out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
        else $error("Zero-length word carries a nonzero direction.");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            out_data.dir_x <= 32'sd1073741824 && out_data.dir_x >= -32'sd1073741824 &&
            out_data.dir_y <= 32'sd1073741824 && out_data.dir_y >= -32'sd1073741824 &&
            out_data.dir_z <= 32'sd1073741824 && out_data.dir_z >= -32'sd1073741824)
        else $error("Direction component exceeds unit magnitude.");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid))
        else $error("Input stalled without a waiting output word.");

endmodule

bind pinhole_ray_direction_top prd_checker u_prd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pinhole ray direction testbench
// Drives pixel words through the primary ray block under random idling and a
// long output stall, predicts each unit direction from its own fixed-point
// model of the camera and checks every direction word in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 160;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    prd_pkg::ray_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    prd_pkg::ray_out_t out_data;
    logic     cfg_write = 1'b0;
    logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [prd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [12:0]        cam_cols;
    logic [12:0]        cam_rows;
    logic [30:0]        cam_width;
    logic [30:0]        cam_height;
    logic signed [31:0] cam_eye_x;
    logic signed [31:0] cam_eye_y;
    logic signed [31:0] cam_eye_z;
    logic               cam_jitter;

    prd_pkg::ray_out_t pending_dirs[$];
    int       errors = 0;
    int       cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       stall_left = 0;
    bit       stall_req = 0;

    pinhole_ray_direction_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic longint window_point(logic [11:0] pix, logic signed [15:0] jit,
                                            logic [12:0] count, logic [30:0] extent);
        longint c;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint unsigned cnt;
        bit neg;
        c = longint'(pix) << prd_pkg::JIT_FRAC;
        if (cam_jitter)
            c += longint'(jit);
        neg = c < 0;
        mag = neg ? -c : c;
        cnt = (count == 0) ? 1 : count;
        mag = mag * longint'(extent);
        den = cnt << prd_pkg::JIT_FRAC;
        q = (mag + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic prd_pkg::ray_out_t ray_direction(prd_pkg::ray_in_t w);
        longint v[3];
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        bit neg[3];
        int nb;
        prd_pkg::ray_out_t r;
        v[0] = window_point(w.pixel_x, w.jitter_x, cam_cols, cam_width) - longint'(cam_eye_x);
        v[1] = window_point(w.pixel_y, w.jitter_y, cam_rows, cam_height) - longint'(cam_eye_y);
        v[2] = -longint'(cam_eye_z);
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i] = neg[i] ? -v[i] : v[i];
        end
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        r = '0;
        if (mx == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        nb = 0;
        while (nb < 64 && (mx >> nb) != 0)
            nb++;
        for (int i = 0; i < 3; i++)
            m[i] = (nb > 31) ? (m[i] >> (nb - 31)) : (m[i] << (31 - nb));
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << prd_pkg::OUT_FRAC) + len / 2) / len;
            if (neg[i])
                q = -q;
            if (i == 0) r.dir_x = q[31:0];
            else if (i == 1) r.dir_y = q[31:0];
            else r.dir_z = q[31:0];
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge clk)
    begin
        prd_pkg::ray_out_t want;
        if (out_valid && out_ready)
        begin
            if (pending_dirs.size() == 0)
                report("unexpected direction word", 1, 0);
            else
            begin
                want = pending_dirs.pop_front();
                if (out_data.dir_x !== want.dir_x) report("dir_x", out_data.dir_x, want.dir_x);
                if (out_data.dir_y !== want.dir_y) report("dir_y", out_data.dir_y, want.dir_y);
                if (out_data.dir_z !== want.dir_z) report("dir_z", out_data.dir_z, want.dir_z);
                if (out_data.zero_length !== want.zero_length)
                    report("zero_length", out_data.zero_length, want.zero_length);
            end
        end
        if (stall_req)
        begin
            stall_left = 500;
            stall_req = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("pinhole_ray_direction_top verification failed");
            $finish;
        end
    end

    task automatic write_reg(prd_pkg::cfg_reg_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            prd_pkg::REG_PIXEL_COLUMNS: cam_cols = value[12:0];
            prd_pkg::REG_PIXEL_ROWS:    cam_rows = value[12:0];
            prd_pkg::REG_WINDOW_WIDTH:  cam_width = value[30:0];
            prd_pkg::REG_WINDOW_HEIGHT: cam_height = value[30:0];
            prd_pkg::REG_EYE_X:         cam_eye_x = value;
            prd_pkg::REG_EYE_Y:         cam_eye_y = value;
            prd_pkg::REG_EYE_Z:         cam_eye_z = value;
            prd_pkg::REG_JITTER_ENABLE: cam_jitter = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(logic [11:0] px, logic [11:0] py,
                             logic [15:0] jx, logic [15:0] jy);
        prd_pkg::ray_in_t w;
        w.pixel_x = px;
        w.pixel_y = py;
        w.jitter_x = jx;
        w.jitter_y = jy;
        in_data <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_dirs.push_back(ray_direction(w));
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_dirs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_word();
        logic [11:0] px;
        logic [11:0] py;
        px = $urandom;
        py = $urandom;
        if ($urandom_range(3) != 0)
        begin
            px = $urandom_range(cam_cols == 0 ? 0 : cam_cols - 1) & 12'hFFF;
            py = $urandom_range(cam_rows == 0 ? 0 : cam_rows - 1) & 12'hFFF;
        end
        send_word(px, py, $urandom, $urandom);
    endtask

    task automatic randomize_camera();
        write_reg(prd_pkg::REG_PIXEL_COLUMNS,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(4096, 1));
        write_reg(prd_pkg::REG_PIXEL_ROWS,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(4096, 1));
        write_reg(prd_pkg::REG_WINDOW_WIDTH,
                  $urandom_range(1) ? $urandom : $urandom_range(2000000));
        write_reg(prd_pkg::REG_WINDOW_HEIGHT,
                  $urandom_range(1) ? $urandom : $urandom_range(2000000));
        write_reg(prd_pkg::REG_EYE_X,
                  $urandom_range(1) ? $urandom : $urandom_range(2000000) - 1000000);
        write_reg(prd_pkg::REG_EYE_Y,
                  $urandom_range(1) ? $urandom : $urandom_range(2000000) - 1000000);
        write_reg(prd_pkg::REG_EYE_Z,
                  $urandom_range(1) ? $urandom : $urandom_range(2000000) - 1000000);
        write_reg(prd_pkg::REG_JITTER_ENABLE, $urandom);
    endtask

    task automatic test_reset_defaults();
        cam_cols = 640;
        cam_rows = 480;
        cam_width = 524288;
        cam_height = 393216;
        cam_eye_x = 262144;
        cam_eye_y = 196608;
        cam_eye_z = 327680;
        cam_jitter = 1'b0;
        send_word(0, 0, 16'h7FFF, 16'h8000);
        send_word(320, 240, 0, 0);
        send_word(12'hFFF, 12'hFFF, 16'h1234, 16'hFEDC);
        wait_idle();
    endtask

    task automatic test_directed();
        write_reg(prd_pkg::REG_JITTER_ENABLE, 1);
        send_word(0, 0, 16'h8000, 16'h8000);
        send_word(0, 0, 16'h7FFF, 16'h7FFF);
        send_word(12'hFFF, 0, 16'h7FFF, 16'h8000);
        send_word(0, 12'hFFF, 16'h8000, 16'h7FFF);
        send_word(700, 500, 16'h5555, 16'hAAAA);
        wait_idle();
        write_reg(prd_pkg::REG_PIXEL_COLUMNS, 0);
        write_reg(prd_pkg::REG_PIXEL_ROWS, 0);
        send_word(1, 1, 0, 0);
        send_word(12'hFFF, 12'hFFF, 16'h8000, 16'h7FFF);
        wait_idle();
        write_reg(prd_pkg::REG_PIXEL_COLUMNS, 4096);
        write_reg(prd_pkg::REG_PIXEL_ROWS, 13'h1FFF);
        write_reg(prd_pkg::REG_WINDOW_WIDTH, 32'h7FFF_FFFF);
        write_reg(prd_pkg::REG_WINDOW_HEIGHT, 0);
        write_reg(prd_pkg::REG_EYE_X, 32'h8000_0000);
        write_reg(prd_pkg::REG_EYE_Y, 32'h7FFF_FFFF);
        write_reg(prd_pkg::REG_EYE_Z, 32'h8000_0000);
        send_word(12'hFFF, 12'hFFF, 16'h7FFF, 16'h7FFF);
        send_word(0, 2048, 16'h8000, 0);
        wait_idle();
        write_reg(prd_pkg::REG_JITTER_ENABLE, 0);
        write_reg(prd_pkg::REG_EYE_X, 0);
        write_reg(prd_pkg::REG_EYE_Y, 0);
        write_reg(prd_pkg::REG_EYE_Z, 0);
        write_reg(prd_pkg::REG_WINDOW_HEIGHT, 32'h7FFF_FFFF);
        send_word(0, 0, 16'h7FFF, 16'h8000);
        send_word(12'hFFF, 12'hFFF, 0, 0);
        wait_idle();
        write_reg(prd_pkg::REG_EYE_Z, 32'h7FFF_FFFF);
        send_word(0, 0, 0, 0);
        wait_idle();
        write_reg(prd_pkg::REG_WINDOW_WIDTH, 0);
        write_reg(prd_pkg::REG_WINDOW_HEIGHT, 0);
        write_reg(prd_pkg::REG_EYE_Z, 0);
        send_word(12'hABC, 12'h543, 16'h0001, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_random_phase(int sender_pct, int receiver_pct, int words);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int n = 0; n < words; n++)
        begin
            if (n % 100 == 0)
            begin
                wait_idle();
                randomize_camera();
            end
            send_random_word();
        end
        wait_idle();
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        stall_req = 1;
        @(posedge clk);
        for (int n = 0; n < 250; n++)
            send_random_word();
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random_phase(10, 86, 400);
        test_random_phase(86, 10, 400);
        test_random_phase(0, 0, 450);
        test_output_stall();
        if (errors == 0)
            $display("pinhole_ray_direction_top verification clean");
        else
            $display("pinhole_ray_direction_top verification failed");
        $finish;
    end

endmodule
